@@ rtl/core/tree_lca_binary_lifting_assert.svh @@
// Assertion macros for the tree LCA engine. All checks are sampled on clk
// and are off while rst_n is low.
`ifndef TREE_LCA_BINARY_LIFTING_ASSERT_SVH
`define TREE_LCA_BINARY_LIFTING_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define TLB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define TLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tlb_pkg.sv @@
package tlb_pkg;

  localparam int NODE_W   = 10;
  localparam int CNT_W    = 11;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 26;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 11'd1024;

  typedef enum logic [1:0] {
    ACT_ADD_EDGE = 2'd0,
    ACT_BUILD    = 2'd1,
    ACT_QUERY    = 2'd2
  } action_t;

  localparam logic KIND_BUILD   = 1'b0;
  localparam logic KIND_QUERY   = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // which of the three LCA searches of a query is running
  typedef enum logic [1:0] {
    PAIR_AB = 2'd0,
    PAIR_AR = 2'd1,
    PAIR_BR = 2'd2
  } pair_t;

  typedef struct packed {
    logic [1:0]          action;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [WEIGHT_W-1:0] edge_weight;
    logic [NODE_W-1:0]   root_node;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic              status;
    logic [NODE_W-1:0] ancestor;
    logic [NODE_W-1:0] rerooted_ancestor;
    logic [DIST_W-1:0] distance;
  } out_item_t;

endpackage

@@ rtl/core/tree_lca_binary_lifting.sv @@
// Tree LCA engine. Add-edge items give no item back.
// A build clears the node memory, walks the tree depth-first (for every
// node popped, each loaded edge is fetched and checked), then fills the
// jump table, level 0 from the parents and each higher level from the
// level below. A query runs three lifting searches, then reads the root
// distances of both nodes and of their ancestor. Out-of-range builds and
// queries answer the next cycle. busy is high while an item is in work;
// each result is shown for one cycle with out_strobe and cannot be held
// off.
`include "tree_lca_binary_lifting_assert.svh"

module tree_lca_binary_lifting #(
  parameter int MAX_NODES   = 1024,
  parameter int JUMP_LEVELS = 10,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  tlb_pkg::in_item_t         in_item,
  output logic                      out_strobe,
  output tlb_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  logic [tlb_pkg::CNT_W-1:0] cfg_data
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int PW = $clog2(MAX_NODES + 1);
  localparam int XW = (PW > tlb_pkg::CNT_W) ? PW : tlb_pkg::CNT_W;
  localparam int KW = (JUMP_LEVELS > 1) ? $clog2(JUMP_LEVELS) : 1;
  localparam int EW = (WEIGHT_BITS < tlb_pkg::WEIGHT_W) ? WEIGHT_BITS : tlb_pkg::WEIGHT_W;
  localparam int LW = ((NW > 16) ? NW : 16) + 2;
  localparam int DW = tlb_pkg::DIST_W;
  localparam int JM_DEPTH = MAX_NODES * (2 ** KW);
  localparam int NS = 31;

  localparam logic [PW-1:0] NO_NODE   = PW'(MAX_NODES);
  localparam logic [NW-1:0] LAST_NODE = NW'(MAX_NODES - 1);
  localparam logic [KW-1:0] TOP_LEVEL = KW'(JUMP_LEVELS - 1);

  typedef struct packed {
    logic          seen;
    logic [PW-1:0] parent;
    logic [NW-1:0] depth;
    logic [DW-1:0] rdist;
  } node_rec_t;

  typedef struct packed {
    logic [NW-1:0] end_a;
    logic [NW-1:0] end_b;
    logic [EW-1:0] cost;
  } edge_rec_t;

  typedef enum logic [NS-1:0] {
    S_IDLE  = NS'(1) << 0,
    S_CLR   = NS'(1) << 1,
    S_ROOT  = NS'(1) << 2,
    S_POP   = NS'(1) << 3,
    S_UREAD = NS'(1) << 4,
    S_ULAT  = NS'(1) << 5,
    S_EREQ  = NS'(1) << 6,
    S_EDAT  = NS'(1) << 7,
    S_VCHK  = NS'(1) << 8,
    S_F0R   = NS'(1) << 9,
    S_F0W   = NS'(1) << 10,
    S_FKR1  = NS'(1) << 11,
    S_FKR2  = NS'(1) << 12,
    S_FKW   = NS'(1) << 13,
    S_LP    = NS'(1) << 14,
    S_LQ    = NS'(1) << 15,
    S_LSW   = NS'(1) << 16,
    S_L1R   = NS'(1) << 17,
    S_L1D   = NS'(1) << 18,
    S_L1E   = NS'(1) << 19,
    S_L2A   = NS'(1) << 20,
    S_L2B   = NS'(1) << 21,
    S_L2C   = NS'(1) << 22,
    S_L2P   = NS'(1) << 23,
    S_L2Q   = NS'(1) << 24,
    S_LRET  = NS'(1) << 25,
    S_DA    = NS'(1) << 26,
    S_DB    = NS'(1) << 27,
    S_DX    = NS'(1) << 28,
    S_DFIN  = NS'(1) << 29,
    S_SPARE = NS'(1) << 30
  } state_t;

  state_t state_r, state_nxt;

  // control registers
  logic [tlb_pkg::CNT_W-1:0] node_count_r;
  logic [NW-1:0]             edges_r;
  logic [NW:0]               sp_r;
  logic                      out_strobe_r, out_strobe_nxt;
  tlb_pkg::out_item_t        out_item_r, out_item_nxt;

  // datapath registers
  logic [XW-1:0]   cnt_r;
  logic [NW-1:0]   qa_r, qb_r, qr_r;
  logic [NW-1:0]   i_r, e_r, u_r, v_r;
  logic [KW-1:0]   k_r;
  logic [NW-1:0]   du_r;
  logic [DW-1:0]   ru_r;
  logic [EW-1:0]   w_r;
  logic [NW-1:0]   lu_r, lv_r, ldu_r, ldv_r;
  logic [PW-1:0]   au_r, lres_r, x_r, y_r, z_r;
  logic [DW-1:0]   ra_r, rb_r;
  tlb_pkg::pair_t  lidx_r;

  // memories and their ports
  node_rec_t     node_mem [MAX_NODES];
  edge_rec_t     edge_mem [MAX_NODES-1];
  logic [PW-1:0] jump_mem [JM_DEPTH];
  logic [NW-1:0] stack_mem [MAX_NODES];

  node_rec_t       nm_rd_r, nm_wd;
  logic [NW-1:0]   nm_ra, nm_wa;
  logic            nm_we;
  edge_rec_t       em_rd_r, em_wd;
  logic [NW-1:0]   em_ra;
  logic            em_we;
  logic [PW-1:0]   jm_rd_r, jm_wd;
  logic [NW+KW-1:0] jm_ra, jm_wa;
  logic            jm_we;
  logic [NW-1:0]   stk_rd_r, stk_ra, stk_wa, stk_wd;
  logic            stk_we;

  // input decode
  logic          acc;
  logic [XW-1:0] cnt_now;
  logic          a_ok, b_ok, r_ok, edge_add;

  assign busy = (state_r != S_IDLE);
  assign acc  = start && !busy;

  always_comb begin
    if (node_count_r == '0) begin
      cnt_now = XW'(1);
    end else if (XW'(node_count_r) > XW'(MAX_NODES)) begin
      cnt_now = XW'(MAX_NODES);
    end else begin
      cnt_now = XW'(node_count_r);
    end
  end

  assign a_ok = XW'(in_item.node_a) < cnt_now;
  assign b_ok = XW'(in_item.node_b) < cnt_now;
  assign r_ok = XW'(in_item.root_node) < cnt_now;
  assign edge_add = acc && (in_item.action == tlb_pkg::ACT_ADD_EDGE) && a_ok && b_ok &&
                    (edges_r != LAST_NODE);

  // walk helpers: does the fetched edge touch the popped node
  logic          e_ok, hit_a, hit_b, e_hit;
  logic [NW-1:0] e_v;
  assign e_ok  = (XW'(em_rd_r.end_a) < cnt_r) && (XW'(em_rd_r.end_b) < cnt_r);
  assign hit_a = (em_rd_r.end_a == u_r);
  assign hit_b = (em_rd_r.end_b == u_r);
  assign e_v   = hit_a ? em_rd_r.end_b : em_rd_r.end_a;
  assign e_hit = e_ok && (hit_a || hit_b);

  // fill helpers
  logic mid_ok, last_i, last_k, fill_end;
  assign mid_ok   = jm_rd_r < NO_NODE;
  assign last_i   = (i_r == LAST_NODE);
  assign last_k   = (k_r == TOP_LEVEL);
  assign fill_end = last_i && last_k;

  // lifting helpers
  logic [NW-1:0] lp, lq;
  logic [LW-1:0] step;
  logic          jump_ok, l2_ok, x_ok;
  assign lp      = (lidx_r == tlb_pkg::PAIR_BR) ? qb_r : qa_r;
  assign lq      = (lidx_r == tlb_pkg::PAIR_AB) ? qb_r : qr_r;
  assign step    = LW'(1) << k_r;
  assign jump_ok = (LW'(ldv_r) >= LW'(ldu_r) + step) && (jm_rd_r < NO_NODE);
  assign l2_ok   = (au_r != jm_rd_r) && (au_r < NO_NODE) && (jm_rd_r < NO_NODE);
  assign x_ok    = x_r < NO_NODE;

  // rerooted answer by the three-search rule
  logic [PW-1:0] re;
  always_comb begin
    priority if (x_r == z_r && z_r != y_r) begin
      re = y_r;
    end else if (x_r == y_r && z_r != y_r) begin
      re = z_r;
    end else begin
      re = x_r;
    end
  end

  // next state, memory strobes and results
  always_comb begin
    state_nxt      = state_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = '0;
    nm_ra = '0; nm_wa = '0; nm_we = 1'b0; nm_wd = '0;
    em_ra = e_r; em_we = edge_add; em_wd = '0;
    jm_ra = '0; jm_wa = '0; jm_we = 1'b0; jm_wd = '0;
    stk_ra = '0; stk_wa = '0; stk_we = 1'b0; stk_wd = '0;

    em_wd.end_a = NW'(in_item.node_a);
    em_wd.end_b = NW'(in_item.node_b);
    em_wd.cost  = EW'(in_item.edge_weight);

    unique case (state_r)
      S_IDLE: begin
        if (acc && in_item.action == tlb_pkg::ACT_BUILD) begin
          if (r_ok) begin
            state_nxt = S_CLR;
          end else begin
            out_strobe_nxt      = 1'b1;
            out_item_nxt.kind   = tlb_pkg::KIND_BUILD;
            out_item_nxt.status = tlb_pkg::STATUS_RANGE;
          end
        end else if (acc && in_item.action == tlb_pkg::ACT_QUERY) begin
          if (a_ok && b_ok && r_ok) begin
            state_nxt = S_LP;
          end else begin
            out_strobe_nxt      = 1'b1;
            out_item_nxt.kind   = tlb_pkg::KIND_QUERY;
            out_item_nxt.status = tlb_pkg::STATUS_RANGE;
          end
        end
      end
      // clear every node record
      S_CLR: begin
        nm_we = 1'b1;
        nm_wa = i_r;
        nm_wd.parent = NO_NODE;
        if (last_i) state_nxt = S_ROOT;
      end
      S_ROOT: begin
        nm_we = 1'b1;
        nm_wa = qr_r;
        nm_wd.seen = 1'b1;
        nm_wd.parent = NO_NODE;
        stk_we = 1'b1;
        stk_wa = '0;
        stk_wd = qr_r;
        state_nxt = S_POP;
      end
      // depth-first walk
      S_POP: begin
        if (sp_r == '0) begin
          state_nxt = S_F0R;
        end else begin
          stk_ra = NW'(sp_r - 1'b1);
          state_nxt = S_UREAD;
        end
      end
      S_UREAD: begin
        nm_ra = stk_rd_r;
        state_nxt = S_ULAT;
      end
      S_ULAT: state_nxt = S_EREQ;
      S_EREQ: begin
        state_nxt = (e_r == edges_r) ? S_POP : S_EDAT;
      end
      S_EDAT: begin
        nm_ra = e_v;
        state_nxt = e_hit ? S_VCHK : S_EREQ;
      end
      S_VCHK: begin
        if (!nm_rd_r.seen) begin
          nm_we = 1'b1;
          nm_wa = v_r;
          nm_wd.seen   = 1'b1;
          nm_wd.parent = PW'(u_r);
          nm_wd.depth  = du_r + 1'b1;
          nm_wd.rdist  = ru_r + DW'(w_r);
          if (sp_r < (NW+1)'(MAX_NODES)) begin
            stk_we = 1'b1;
            stk_wa = NW'(sp_r);
            stk_wd = v_r;
          end
        end
        state_nxt = S_EREQ;
      end
      // level 0 of the jump table is the parent
      S_F0R: begin
        nm_ra = i_r;
        state_nxt = S_F0W;
      end
      S_F0W: begin
        jm_we = 1'b1;
        jm_wa = {i_r, KW'(0)};
        jm_wd = nm_rd_r.parent;
        if (!last_i) begin
          state_nxt = S_F0R;
        end else if (JUMP_LEVELS == 1) begin
          state_nxt = S_IDLE;
          out_strobe_nxt    = 1'b1;
          out_item_nxt.kind = tlb_pkg::KIND_BUILD;
        end else begin
          state_nxt = S_FKR1;
        end
      end
      // higher levels: jump twice by the level below
      S_FKR1: begin
        jm_ra = {i_r, KW'(k_r - 1'b1)};
        state_nxt = S_FKR2;
      end
      S_FKR2: begin
        if (mid_ok) begin
          jm_ra = {NW'(jm_rd_r), KW'(k_r - 1'b1)};
          state_nxt = S_FKW;
        end else begin
          jm_we = 1'b1;
          jm_wa = {i_r, k_r};
          jm_wd = NO_NODE;
          state_nxt = fill_end ? S_IDLE : S_FKR1;
          if (fill_end) begin
            out_strobe_nxt    = 1'b1;
            out_item_nxt.kind = tlb_pkg::KIND_BUILD;
          end
        end
      end
      S_FKW: begin
        jm_we = 1'b1;
        jm_wa = {i_r, k_r};
        jm_wd = jm_rd_r;
        state_nxt = fill_end ? S_IDLE : S_FKR1;
        if (fill_end) begin
          out_strobe_nxt    = 1'b1;
          out_item_nxt.kind = tlb_pkg::KIND_BUILD;
        end
      end
      // one LCA search: fetch depths
      S_LP: begin
        nm_ra = lp;
        state_nxt = S_LQ;
      end
      S_LQ: begin
        nm_ra = lq;
        state_nxt = S_LSW;
      end
      S_LSW: state_nxt = S_L1R;
      // lift the deeper node to the same depth
      S_L1R: begin
        jm_ra = {lv_r, k_r};
        state_nxt = S_L1D;
      end
      S_L1D: state_nxt = (k_r == '0) ? S_L1E : S_L1R;
      S_L1E: state_nxt = (lu_r == lv_r) ? S_LRET : S_L2A;
      // lift both while their ancestors differ
      S_L2A: begin
        jm_ra = {lu_r, k_r};
        state_nxt = S_L2B;
      end
      S_L2B: begin
        jm_ra = {lv_r, k_r};
        state_nxt = S_L2C;
      end
      S_L2C: state_nxt = (k_r == '0) ? S_L2P : S_L2A;
      S_L2P: begin
        jm_ra = {lu_r, KW'(0)};
        state_nxt = S_L2Q;
      end
      S_L2Q: state_nxt = S_LRET;
      S_LRET: state_nxt = (lidx_r == tlb_pkg::PAIR_BR) ? S_DA : S_LP;
      // root distances of both nodes and of their ancestor
      S_DA: begin
        nm_ra = qa_r;
        state_nxt = S_DB;
      end
      S_DB: begin
        nm_ra = qb_r;
        state_nxt = S_DX;
      end
      S_DX: begin
        nm_ra = NW'(x_r);
        state_nxt = S_DFIN;
      end
      S_DFIN: begin
        out_strobe_nxt    = 1'b1;
        out_item_nxt.kind = tlb_pkg::KIND_QUERY;
        out_item_nxt.ancestor = x_ok ? tlb_pkg::NODE_W'(x_r) : '0;
        out_item_nxt.rerooted_ancestor = (re < NO_NODE) ? tlb_pkg::NODE_W'(re) : '0;
        out_item_nxt.distance = ra_r + rb_r -
                                (x_ok ? DW'({nm_rd_r.rdist, 1'b0}) : DW'(0));
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= tlb_pkg::NODE_COUNT_RST;
      edges_r      <= '0;
      sp_r         <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) node_count_r <= cfg_data;
      if (edge_add) edges_r <= edges_r + 1'b1;
      if (state_r == S_ROOT) begin
        sp_r <= (NW+1)'(1);
      end else if (state_r == S_POP && sp_r != '0) begin
        sp_r <= sp_r - 1'b1;
      end else if (state_r == S_VCHK && !nm_rd_r.seen && sp_r < (NW+1)'(MAX_NODES)) begin
        sp_r <= sp_r + 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    unique case (state_r)
      S_IDLE: begin
        qa_r   <= NW'(in_item.node_a);
        qb_r   <= NW'(in_item.node_b);
        qr_r   <= NW'(in_item.root_node);
        cnt_r  <= cnt_now;
        i_r    <= '0;
        lidx_r <= tlb_pkg::PAIR_AB;
      end
      S_CLR: i_r <= last_i ? '0 : i_r + 1'b1;
      S_POP: i_r <= '0;
      S_UREAD: u_r <= stk_rd_r;
      S_ULAT: begin
        du_r <= nm_rd_r.depth;
        ru_r <= nm_rd_r.rdist;
        e_r  <= '0;
      end
      S_EDAT: begin
        v_r <= e_v;
        w_r <= em_rd_r.cost;
        if (!e_hit) e_r <= e_r + 1'b1;
      end
      S_VCHK: e_r <= e_r + 1'b1;
      S_F0W: begin
        i_r <= last_i ? '0 : i_r + 1'b1;
        if (last_i) k_r <= KW'(1);
      end
      S_FKR2: begin
        if (!mid_ok) begin
          i_r <= last_i ? '0 : i_r + 1'b1;
          if (last_i) k_r <= k_r + 1'b1;
        end
      end
      S_FKW: begin
        i_r <= last_i ? '0 : i_r + 1'b1;
        if (last_i) k_r <= k_r + 1'b1;
      end
      S_LQ: ldu_r <= nm_rd_r.depth;
      S_LSW: begin
        // keep the shallower node in lu
        if (ldu_r > nm_rd_r.depth) begin
          lu_r <= lq; lv_r <= lp;
          ldu_r <= nm_rd_r.depth; ldv_r <= ldu_r;
        end else begin
          lu_r <= lp; lv_r <= lq;
          ldv_r <= nm_rd_r.depth;
        end
        k_r <= TOP_LEVEL;
      end
      S_L1D: begin
        if (jump_ok) begin
          lv_r  <= NW'(jm_rd_r);
          ldv_r <= NW'(LW'(ldv_r) - step);
        end
        if (k_r != '0) k_r <= k_r - 1'b1;
      end
      S_L1E: begin
        if (lu_r == lv_r) lres_r <= PW'(lu_r);
        k_r <= TOP_LEVEL;
      end
      S_L2B: au_r <= jm_rd_r;
      S_L2C: begin
        if (l2_ok) begin
          lu_r <= NW'(au_r);
          lv_r <= NW'(jm_rd_r);
        end
        if (k_r != '0) k_r <= k_r - 1'b1;
      end
      S_L2Q: lres_r <= jm_rd_r;
      S_LRET: begin
        unique case (lidx_r)
          tlb_pkg::PAIR_AB: begin x_r <= lres_r; lidx_r <= tlb_pkg::PAIR_AR; end
          tlb_pkg::PAIR_AR: begin y_r <= lres_r; lidx_r <= tlb_pkg::PAIR_BR; end
          default:          z_r <= lres_r;
        endcase
      end
      S_DB: ra_r <= nm_rd_r.rdist;
      S_DX: rb_r <= nm_rd_r.rdist;
      default: ;
    endcase
  end

  // node record memory
  always_ff @(posedge clk) begin
    if (nm_we) node_mem[nm_wa] <= nm_wd;
    nm_rd_r <= node_mem[nm_ra];
  end

  // edge memory
  always_ff @(posedge clk) begin
    if (em_we) edge_mem[edges_r] <= em_wd;
    em_rd_r <= edge_mem[em_ra];
  end

  // jump table memory, address {node, level}
  always_ff @(posedge clk) begin
    if (jm_we) jump_mem[jm_wa] <= jm_wd;
    jm_rd_r <= jump_mem[jm_ra];
  end

  // walk stack memory
  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_wa] <= stk_wd;
    stk_rd_r <= stack_mem[stk_ra];
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // checks
  `TLB_ASSERT_NEXT(a_query_busy, acc && in_item.action == tlb_pkg::ACT_QUERY && a_ok && b_ok && r_ok, busy, "in-range query did not start")
  `TLB_ASSERT_NOW(a_stack_bound, 1'b1, sp_r <= (NW+1)'(MAX_NODES), "walk stack overflow")
  `TLB_ASSERT_NOW(a_edge_cap, 1'b1, edges_r <= LAST_NODE, "edge count beyond capacity")
  `TLB_ASSERT_NOW(a_result_cause, out_strobe, $past(start) || $past(busy), "result without an item")

endmodule
